>>> hdl/variable_run_length_decoder_assert.svh
// assertion macros used by the checker module of the run-length decoder
// depends on a clock named clk and an active-low reset named arst_n in scope
`ifndef VARIABLE_RUN_LENGTH_DECODER_ASSERT_SVH
`define VARIABLE_RUN_LENGTH_DECODER_ASSERT_SVH

// property that holds at every edge outside reset
`define VRLD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// property whose consequent holds in the cycle after its antecedent
`define VRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/vrld_pkg.sv
// types and constants of the variable run-length decoder
// no dependencies; imported by every module of the block
package vrld_pkg;

	localparam int IMAGE_WIDTH = 320;
	localparam int COL_W       = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
	localparam int SIZE_W      = 18;
	localparam int INTEN_W     = 4;
	localparam int ROW_W       = 10;
	localparam int ROW_SUM_W   = SIZE_W + 1;
	localparam logic [ROW_W-1:0] ROW_MAX = 10'd1023;

	// reciprocal of the width, scaled so that the quotient estimate is off by at most one
	localparam int RECIP_SHIFT = SIZE_W;
	localparam int RECIP_W     = SIZE_W + 1;
	localparam int PROD_W      = SIZE_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / IMAGE_WIDTH);
	localparam logic [SIZE_W-1:0]  WIDTH_SZ = SIZE_W'(IMAGE_WIDTH);

	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// bytes held of an unfinished code
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	typedef struct packed {
		logic                clear;
		logic [SIZE_W-1:0]   size;
		logic [INTEN_W-1:0]  intensity;
		logic [SIZE_W-1:0]   wraps;
		logic [COL_W-1:0]    col_step;
	} run_entry_t;

endpackage

>>> hdl/vrld_if.sv
// handshake channels of the run-length decoder: compressed bytes in, run descriptors out
// depends on nothing but plain logic types
interface vrld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_image;

	modport source (output valid, data_byte, start_of_image, input ready);
	modport sink (input valid, data_byte, start_of_image, output ready);
endinterface

interface vrld_run_if;
	logic        valid;
	logic        ready;
	logic [17:0] run_length;
	logic [31:0] pixel_color;
	logic [8:0]  start_column;
	logic [9:0]  start_row;

	modport source (output valid, run_length, pixel_color, start_column, start_row,
		input ready);
	modport sink (input valid, run_length, pixel_color, start_column, start_row,
		output ready);
endinterface

>>> hdl/vrld_front.sv
// front end: assembles run codes from bytes and splits each size into wraps and column step
// depends on vrld_pkg and vrld_byte_if
module vrld_front (
	input  logic                 clk,
	input  logic                 arst_n,
	vrld_byte_if.sink            bytes,
	output vrld_pkg::run_entry_t push_entry,
	output logic                 push_valid,
	input  logic                 push_ready
);
	import vrld_pkg::*;

	logic [1:0]          held_q;
	logic [15:0]         partial_q;
	logic                clear_pend_q;

	logic                v1_s1, v2_s2, v3_s3;
	logic [SIZE_W-1:0]   size_s1, size_s2, size_s3;
	logic [INTEN_W-1:0]  inten_s1, inten_s2, inten_s3;
	logic                clr_s1, clr_s2, clr_s3;
	logic [PROD_W-1:0]   prod_s2;
	logic [SIZE_W-1:0]   qest_s3, qw_s3;

	logic                adv, accept;
	logic [1:0]          held_eff, held_nxt;
	logic [15:0]         part_eff, part_nxt;
	logic [15:0]         code16;
	logic                done;
	logic [SIZE_W-1:0]   size_c;
	logic [INTEN_W-1:0]  inten_c;
	logic                emit;
	logic [SIZE_W+12:0]  qw_full;
	logic [SIZE_W-1:0]   rem, rem_fix;
	logic                fix;

	assign adv         = !v3_s3 || push_ready;
	assign bytes.ready = adv;
	assign accept      = bytes.valid && adv;

	// code assembly; start of image drops any partial code first
	always_comb begin
		held_eff = bytes.start_of_image ? HELD_NONE : held_q;
		part_eff = bytes.start_of_image ? 16'h0000 : partial_q;
		code16   = {bytes.data_byte, part_eff[7:0]};
		held_nxt = held_eff;
		part_nxt = part_eff;
		done     = 1'b0;
		size_c   = '0;
		inten_c  = '0;
		unique case (held_eff)
			HELD_ONE: begin
				if (code16[1]) begin
					done    = 1'b1;
					size_c  = SIZE_W'(code16[11:2]);
					inten_c = code16[15:12];
				end else begin
					held_nxt = HELD_TWO;
					part_nxt = code16;
				end
			end
			HELD_TWO: begin
				done    = 1'b1;
				size_c  = {bytes.data_byte[3:0], part_eff[15:2]};
				inten_c = bytes.data_byte[7:4];
			end
			default: begin
				if (bytes.data_byte[0]) begin
					done    = 1'b1;
					size_c  = SIZE_W'(bytes.data_byte[3:1]);
					inten_c = bytes.data_byte[7:4];
				end else begin
					held_nxt = HELD_ONE;
					part_nxt = {8'h00, bytes.data_byte};
				end
			end
		endcase
		if (done) begin
			held_nxt = HELD_NONE;
			part_nxt = 16'h0000;
		end
		emit = done && (size_c != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= HELD_NONE;
			partial_q    <= 16'h0000;
			clear_pend_q <= 1'b0;
		end else if (accept) begin
			held_q    <= held_nxt;
			partial_q <= part_nxt;
			// a clear with no run behind it yet rides on the next run
			if (emit)
				clear_pend_q <= 1'b0;
			else if (bytes.start_of_image)
				clear_pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= accept && emit;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	assign qw_full = (SIZE_W+13)'(prod_s2[RECIP_SHIFT +: SIZE_W]) * (SIZE_W+13)'(IMAGE_WIDTH);

	always_ff @(posedge clk) begin
		if (adv) begin
			size_s1  <= size_c;
			inten_s1 <= inten_c;
			clr_s1   <= bytes.start_of_image || clear_pend_q;

			size_s2  <= size_s1;
			inten_s2 <= inten_s1;
			clr_s2   <= clr_s1;
			prod_s2  <= PROD_W'(size_s1) * PROD_W'(RECIP);

			size_s3  <= size_s2;
			inten_s3 <= inten_s2;
			clr_s3   <= clr_s2;
			qest_s3  <= prod_s2[RECIP_SHIFT +: SIZE_W];
			qw_s3    <= qw_full[SIZE_W-1:0];
		end
	end

	// estimate is low by at most one width
	always_comb begin
		rem     = size_s3 - qw_s3;
		fix     = (rem >= WIDTH_SZ);
		rem_fix = fix ? (rem - WIDTH_SZ) : rem;
		push_entry.clear     = clr_s3;
		push_entry.size      = size_s3;
		push_entry.intensity = inten_s3;
		push_entry.wraps     = qest_s3 + SIZE_W'(fix);
		push_entry.col_step  = rem_fix[COL_W-1:0];
	end

	assign push_valid = v3_s3;

endmodule

>>> hdl/vrld_queue.sv
// short queue of decoded runs between the front and back ends
// depends on vrld_pkg
module vrld_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vrld_pkg::run_entry_t wr_entry,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	output vrld_pkg::run_entry_t rd_entry,
	output logic                 rd_valid,
	input  logic                 rd_ready
);
	import vrld_pkg::*;

	run_entry_t          slots_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]    count_q;
	logic                do_wr, do_rd;

	assign wr_ready = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slots_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hdl/vrld_back.sv
// back end: keeps the raster position, builds each descriptor and holds it for the receiver
// depends on vrld_pkg and vrld_run_if
module vrld_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vrld_pkg::run_entry_t entry,
	input  logic                 entry_valid,
	output logic                 entry_ready,
	vrld_run_if.source           runs
);
	import vrld_pkg::*;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 out_valid_q;
	logic [SIZE_W-1:0]    length_q;
	logic [31:0]          color_q;
	logic [8:0]           column_q;
	logic [ROW_W-1:0]     start_row_q;

	logic                 take;
	logic [COL_W-1:0]     base_col, new_col;
	logic [ROW_W-1:0]     base_row, new_row;
	logic [COL_W:0]       col_sum;
	logic                 wrap;
	logic [ROW_SUM_W-1:0] row_sum;
	logic [COL_W+8:0]     col_ext;

	assign entry_ready = !out_valid_q || runs.ready;
	assign take        = entry_valid && entry_ready;

	always_comb begin
		base_col = entry.clear ? '0 : col_q;
		base_row = entry.clear ? '0 : row_q;
		col_sum  = {1'b0, base_col} + {1'b0, entry.col_step};
		wrap     = (col_sum >= (COL_W+1)'(IMAGE_WIDTH));
		new_col  = wrap ? COL_W'(col_sum - (COL_W+1)'(IMAGE_WIDTH)) : col_sum[COL_W-1:0];
		row_sum  = ROW_SUM_W'(base_row) + ROW_SUM_W'(entry.wraps) + ROW_SUM_W'(wrap);
		// row saturates at the last row
		new_row  = (row_sum > ROW_SUM_W'(ROW_MAX)) ? ROW_MAX : row_sum[ROW_W-1:0];
		col_ext  = {9'b0, base_col};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				col_q       <= new_col;
				row_q       <= new_row;
				out_valid_q <= 1'b1;
			end else if (runs.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			length_q    <= entry.size;
			color_q     <= ALPHA_OPAQUE | {16'h0000, entry.intensity, entry.intensity, 8'h00};
			column_q    <= col_ext[8:0];
			start_row_q <= base_row;
		end
	end

	assign runs.valid        = out_valid_q;
	assign runs.run_length   = length_q;
	assign runs.pixel_color  = color_q;
	assign runs.start_column = column_q;
	assign runs.start_row    = start_row_q;

endmodule

>>> hdl/variable_run_length_decoder.sv
// variable run-length decoder: byte stream in, one run descriptor per nonzero run out
// depends on vrld_pkg, vrld_if, vrld_front, vrld_queue and vrld_back
//
// code_bytes carries one byte of the compressed image per transfer, with start_of_image
// marking the first byte of a picture; runs carries one descriptor per transfer: length,
// ARGB color and the start column and row in the raster.
// One byte is taken every cycle while the queue between the code assembler and the
// position tracker has room; runs follow at one per cycle while the receiver is ready.
// A run passes the three stage front end (code capture, reciprocal multiply, back
// multiply, then a combinational correction of the divide-by-width split), a queue
// slot and the output register in the back end.
// Zero-length codes give no transfer on runs.
// Reset clears the partial code, the raster position and all valid flags; no pass over
// storage is needed afterwards.
// When the receiver stalls, the held descriptor stays unchanged, up to four runs collect
// in the queue, then code_bytes.ready drops once a run waits in the last front stage.
module variable_run_length_decoder (
	input logic        clk,
	input logic        arst_n,
	vrld_byte_if.sink  code_bytes,
	vrld_run_if.source runs
);
	import vrld_pkg::*;

	run_entry_t push_entry, pop_entry;
	logic       push_valid, push_ready;
	logic       pop_valid, pop_ready;

	vrld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (code_bytes),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	vrld_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_entry (push_entry),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_entry (pop_entry),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready)
	);

	vrld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (pop_entry),
		.entry_valid (pop_valid),
		.entry_ready (pop_ready),
		.runs        (runs)
	);

endmodule

>>> hdl/vrld_checker.sv
// port-level checks on the run-length decoder, bound to the top level
// depends on vrld_pkg and variable_run_length_decoder_assert.svh
`include "variable_run_length_decoder_assert.svh"

module vrld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [17:0] run_length,
	input logic [31:0] pixel_color,
	input logic [8:0]  start_column,
	input logic [9:0]  start_row
);
	import vrld_pkg::*;

	// a stalled descriptor holds
	`VRLD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(run_length) && $stable(pixel_color) && $stable(start_column) && $stable(start_row), "stalled run descriptor changed")

	`VRLD_ASSERT_ALWAYS(a_len_nonzero, !out_valid || (run_length != 18'd0), "zero-length run emitted")

	// opaque, green only, green a doubled nibble
	`VRLD_ASSERT_ALWAYS(a_color_form, !out_valid || ((pixel_color[31:24] == 8'hFF) && (pixel_color[23:16] == 8'h00) && (pixel_color[7:0] == 8'h00) && (pixel_color[15:12] == pixel_color[11:8])), "malformed pixel colour")

	`VRLD_ASSERT_ALWAYS(a_col_range, !out_valid || (IMAGE_WIDTH > 512) || (int'(start_column) < IMAGE_WIDTH), "start column beyond image width")

endmodule

bind variable_run_length_decoder vrld_checker u_vrld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (runs.valid),
	.out_ready    (runs.ready),
	.run_length   (runs.run_length),
	.pixel_color  (runs.pixel_color),
	.start_column (runs.start_column),
	.start_row    (runs.start_row)
);
